// File: design/permgen_pkg.sv
// Package for the permutation generator: field widths, op codes and
// status codes shared by the interfaces and the top level.
// No dependencies.
package permgen_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned LETTER_W = 8;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned WORD_W   = LETTER_W * WORD_BYTES;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_STEP   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ORDER = 2'd0,
    ST_FINAL = 2'd1,
    ST_NONE  = 2'd2
  } status_e;

endpackage

// File: design/permgen_in_if.sv
// Input channel of the permutation generator: valid/ready plus op and letter.
// Depends on permgen_pkg.
interface permgen_in_if;
  logic                             valid;
  logic                             ready;
  logic [permgen_pkg::OP_W-1:0]     op;
  logic [permgen_pkg::LETTER_W-1:0] letter;

  modport source (output valid, output op, output letter, input ready);
  modport sink   (input valid, input op, input letter, output ready);
endinterface

// File: design/permgen_out_if.sv
// Output channel of the permutation generator: valid/ready plus word,
// length and status. Depends on permgen_pkg.
interface permgen_out_if;
  logic                             valid;
  logic                             ready;
  logic [permgen_pkg::WORD_W-1:0]   word;
  logic [permgen_pkg::LEN_W-1:0]    length;
  logic [permgen_pkg::STATUS_W-1:0] status;

  modport source (output valid, output word, output length, output status, input ready);
  modport sink   (input valid, input word, input length, input status, output ready);
endinterface

// File: design/permutation_generator_unit.sv
// Permutation generator top level: countdown QuickPerm over a word of up to
// MAX_LETTERS letters. Depends on permgen_pkg, permgen_in_if, permgen_out_if.
//
// Usage:
//   req_i carries one op per word: clear, append a letter, or step. Clear and
//   append give no result; step gives one result word on rsp_o holding the
//   current ordering, its length and a status (ordering, final ordering, or
//   nothing left / empty word).
// Timing:
//   Clear, append and the unused code are taken in S_IDLE, and req_i stays
//   ready after them. A step is accepted in S_IDLE and loaded into the output
//   register from S_EMIT once that register is free. An advancing step then
//   decrements the counter at the cursor in S_DEC, swaps the two letters in
//   S_SWAP, and in S_WALK walks the counters one per cycle until the first
//   nonzero one or the end of the word; a final, exhausted or empty step
//   returns from S_EMIT to S_IDLE. Counters and letters sit in flip-flops,
//   and the one counter read port and one letter read port set this order.
// Stall and reset:
//   While rsp_o is stalled the held result stays put; clear and append are
//   still taken while no step is pending, but a step waits in S_EMIT, with
//   req_i not ready, until the output register frees up. Reset empties the
//   word and restarts the counters; req_i is ready as soon as reset ends.
module permutation_generator_unit #(
  parameter int unsigned MAX_LETTERS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  permgen_in_if.sink      req_i,
  permgen_out_if.source   rsp_o
);
  import permgen_pkg::*;

  localparam int unsigned LW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int unsigned CW = $clog2(MAX_LETTERS + 1);
  localparam int unsigned CD_DEPTH = MAX_LETTERS + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EMIT = 5'b00010,
    S_DEC  = 5'b00100,
    S_SWAP = 5'b01000,
    S_WALK = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [LETTER_W-1:0]     letters_q [MAX_LETTERS];
  logic [LETTER_W-1:0]     letters_d [MAX_LETTERS];
  logic [LEN_W-1:0]        cd_q [CD_DEPTH];
  logic [LEN_W-1:0]        cd_d [CD_DEPTH];
  logic [LEN_W-1:0]        cursor_q, cursor_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic                    fin_q, fin_d;
  logic [LEN_W-1:0]        walk_q, walk_d;
  logic [LW-1:0]           j_q, j_d;
  logic [LETTER_W-1:0]     tmp_q, tmp_d;

  logic                    out_valid_q, out_valid_d;
  logic [WORD_W-1:0]       out_word_q, out_word_d;
  logic [LEN_W-1:0]        out_len_q, out_len_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;

  logic                    in_fire;
  logic                    out_free;
  logic [WORD_W-1:0]       packed_word;
  logic [CW-1:0]           cd_addr;
  logic [LEN_W-1:0]        cd_rd;
  logic [LEN_W-1:0]        cd_dec;
  logic [LW-1:0]           lt_addr;
  logic [LETTER_W-1:0]     lt_rd;
  logic                    no_word;

  assign req_i.ready  = (state_q == S_IDLE);
  assign in_fire      = req_i.valid && req_i.ready;
  assign out_free     = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.word   = out_word_q;
  assign rsp_o.length = out_len_q;
  assign rsp_o.status = out_status_q;

  // Pack the letters below the current length; the rest read as zero
  for (genvar g = 0; g < WORD_BYTES; g++) begin : g_pack
    if (g < MAX_LETTERS) begin : g_live
      assign packed_word[g*LETTER_W +: LETTER_W] =
        (LEN_W'(g) < len_q) ? letters_q[g] : '0;
    end else begin : g_dead
      assign packed_word[g*LETTER_W +: LETTER_W] = '0;
    end
  end

  // Shared read ports: one counter and one letter per cycle
  assign cd_addr = (state_q == S_DEC) ? cursor_q[CW-1:0] : walk_q[CW-1:0];
  assign cd_rd   = cd_q[cd_addr];
  assign cd_dec  = (cd_rd != '0) ? cd_rd - LEN_W'(1) : cd_rd;
  assign lt_addr = (state_q == S_DEC) ? cursor_q[LW-1:0] : j_q;
  assign lt_rd   = letters_q[lt_addr];
  assign no_word = (len_q == '0) || fin_q;

  always_comb begin
    state_d      = state_q;
    letters_d    = letters_q;
    cd_d         = cd_q;
    cursor_d     = cursor_q;
    len_d        = len_q;
    fin_d        = fin_q;
    walk_d       = walk_q;
    j_d          = j_q;
    tmp_d        = tmp_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_word_d   = out_word_q;
    out_len_d    = out_len_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (req_i.op)
            OP_CLEAR: begin
              for (int i = 0; i < MAX_LETTERS; i++) letters_d[i] = '0;
              len_d = '0;
              for (int i = 0; i < CD_DEPTH; i++) cd_d[i] = LEN_W'(i);
              cursor_d = LEN_W'(1);
              fin_d    = 1'b0;
            end
            OP_APPEND: begin
              // ignore the letter once the word is full
              if (len_q < LEN_W'(MAX_LETTERS)) begin
                letters_d[len_q[LW-1:0]] = req_i.letter;
                len_d = len_q + LEN_W'(1);
                for (int i = 0; i < CD_DEPTH; i++) cd_d[i] = LEN_W'(i);
                cursor_d = LEN_W'(1);
                fin_d    = 1'b0;
              end
            end
            OP_STEP: state_d = S_EMIT;
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        // hold until the output register can take the word
        if (out_free) begin
          out_valid_d = 1'b1;
          out_len_d   = len_q;
          if (no_word) begin
            out_word_d   = '0;
            out_status_d = ST_NONE;
            state_d      = S_IDLE;
          end else if (cursor_q >= len_q) begin
            out_word_d   = packed_word;
            out_status_d = ST_FINAL;
            fin_d        = 1'b1;
            state_d      = S_IDLE;
          end else begin
            out_word_d   = packed_word;
            out_status_d = ST_ORDER;
            state_d      = S_DEC;
          end
        end
      end
      S_DEC: begin
        cd_d[cd_addr] = cd_dec;
        // odd cursor swaps with the letter at the new count, even with letter 0
        if (cursor_q[0] && (cd_dec < LEN_W'(MAX_LETTERS))) begin
          j_d = cd_dec[LW-1:0];
        end else begin
          j_d = '0;
        end
        tmp_d   = lt_rd;
        state_d = S_SWAP;
      end
      S_SWAP: begin
        letters_d[cursor_q[LW-1:0]] = lt_rd;
        letters_d[j_q]              = tmp_q;
        walk_d  = LEN_W'(1);
        state_d = S_WALK;
      end
      S_WALK: begin
        // reload exhausted counters and stop at the first live one or at the word length
        if ((walk_q < len_q) && (cd_rd == '0)) begin
          cd_d[cd_addr] = walk_q;
          walk_d        = walk_q + LEN_W'(1);
        end else begin
          cursor_d = walk_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < MAX_LETTERS; i++) letters_q[i] <= '0;
      for (int i = 0; i < CD_DEPTH; i++) cd_q[i] <= LEN_W'(i);
      cursor_q    <= LEN_W'(1);
      len_q       <= '0;
      fin_q       <= 1'b0;
      walk_q      <= LEN_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      letters_q   <= letters_d;
      cd_q        <= cd_d;
      cursor_q    <= cursor_d;
      len_q       <= len_d;
      fin_q       <= fin_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q          <= j_d;
    tmp_q        <= tmp_d;
    out_word_q   <= out_word_d;
    out_len_q    <= out_len_d;
    out_status_q <= out_status_d;
  end

  a_dec_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC) |-> ((cursor_q != '0) && (cursor_q < len_q)))
    else $error("cursor out of range at decrement");

  a_swap_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP) |-> (LEN_W'(j_q) < cursor_q))
    else $error("swap partner not below cursor");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_NONE)) |-> (out_word_q == '0))
    else $error("empty result carries letters");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_LETTERS))
    else $error("word length beyond capacity");

endmodule
